// ===== rtl/tppd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tppd_pkg;

   localparam int WINDOW_LEN = 21;
   localparam int CNT_W      = $clog2(WINDOW_LEN);
   localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_COOLDOWN  = 2'd1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd16393;
   localparam logic [31:0] COOLDOWN_RESET  = 32'd150000;

   // one three-axis sample as held in a window cell
   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } sample_type;

   typedef struct packed {
      logic [15:0] z;
      logic [15:0] y;
      logic [15:0] x;
   } span_type;

   // sequencing from the top level to the min/max tracker
   typedef struct packed {
      logic step;    // sample at the chain tail is valid this cycle
      logic first;   // first sample of a scan
      logic finish;  // form the spans from the running extremes
   } track_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/tppd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one window slot; takes its neighbor's sample whenever the chain moves
module tppd_cell (
   input  wire                       clock,
   input  wire                       shift_en,
   input  wire tppd_pkg::sample_type sample_in,
   output tppd_pkg::sample_type      sample_out
);

   tppd_pkg::sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

// ===== rtl/tppd_track.sv =====
`timescale 1ns / 1ps
`default_nettype none

// running min/max per axis over the samples leaving the chain tail
module tppd_track (
   input  wire                          clock,
   input  wire tppd_pkg::track_ctl_type ctl,
   input  wire tppd_pkg::sample_type    sample_in,
   output tppd_pkg::span_type           span
);

   tppd_pkg::sample_type lo_ff;
   tppd_pkg::sample_type hi_ff;
   tppd_pkg::span_type   span_ff;

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         if (ctl.first || sample_in.x < lo_ff.x) lo_ff.x <= sample_in.x;
         if (ctl.first || sample_in.y < lo_ff.y) lo_ff.y <= sample_in.y;
         if (ctl.first || sample_in.z < lo_ff.z) lo_ff.z <= sample_in.z;
         if (ctl.first || sample_in.x > hi_ff.x) hi_ff.x <= sample_in.x;
         if (ctl.first || sample_in.y > hi_ff.y) hi_ff.y <= sample_in.y;
         if (ctl.first || sample_in.z > hi_ff.z) hi_ff.z <= sample_in.z;
      end
      if (ctl.finish) begin
         // max >= min, so the low 16 bits of the difference are the span
         span_ff.x <= 16'(hi_ff.x - lo_ff.x);
         span_ff.y <= 16'(hi_ff.y - lo_ff.y);
         span_ff.z <= 16'(hi_ff.z - lo_ff.z);
      end
   end

   assign span = span_ff;

endmodule

`default_nettype wire

// ===== rtl/tap_peak_to_peak_detector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tap detector over a sliding window of the last 21 three-axis samples.
// Each accepted req beat (x, y, z, stamp) shifts into a chain of 21 cells;
// the chain then rotates once around while a min/max tracker watches its
// tail. Each sample passes shift-in, the rotation steps, a span cycle
// and a decision cycle, in which the rsp beat is loaded; the next req
// beat can be taken in the cycle after that. Most of the time spent on
// a sample goes to the rotation through the cell chain. The decision
// cycle holds while an earlier rsp beat still waits in the output
// register. A rsp beat is produced for every req beat; tap, warmed and
// spans stay 0 until 21 samples have been seen. A tap is a span strictly
// above threshold_counts on any axis, suppressed when it falls less than
// cooldown_ticks (modulo 2^32) after the last reported tap. The next req
// beat is taken as soon as the core is idle, even while the previous rsp
// beat still waits in its output register. Neither req nor CSR beats are
// taken during reset. CSR writes: index 0 threshold, index 1 cooldown,
// others ignored; write only while idle.
module tap_peak_to_peak_detector_core (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], stamp[79:48]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [79:0] req_tdata,
   // rsp_tdata: tap[0], warmed[1], span_x[17:2], span_y[33:18],
   //            span_z[49:34], zero fill[55:50]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);

   localparam int N = tppd_pkg::WINDOW_LEN;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [tppd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [tppd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic        warm_ff, warm_in;
   logic [31:0] stamp_ff;
   logic [31:0] last_ff;
   logic        had_ff;
   logic        cool_ff;
   logic [15:0] thr_ff;
   logic [31:0] cooldown_ff;
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   logic req_accept;
   logic shift_en;
   logic load_rsp;
   logic over;
   logic tap;

   tppd_pkg::sample_type    new_sample;
   tppd_pkg::sample_type    head_in;
   tppd_pkg::sample_type    chain [N];
   tppd_pkg::track_ctl_type ctl;
   tppd_pkg::span_type      span;
   tppd_pkg::span_type      span_out;

   assign csr_ready  = !reset;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;

   assign new_sample.x = req_tdata[15:0];
   assign new_sample.y = req_tdata[31:16];
   assign new_sample.z = req_tdata[47:32];

   // shift in on acceptance, rotate tail back to head while scanning
   assign shift_en = req_accept || (state_ff == ST_SCAN);
   assign head_in  = (state_ff == ST_IDLE) ? new_sample : chain[N-1];

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            tppd_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .sample_in  (head_in),
               .sample_out (chain[gi])
            );
         end else begin : g_body
            tppd_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .sample_in  (chain[gi-1]),
               .sample_out (chain[gi])
            );
         end
      end
   endgenerate

   assign ctl.step   = (state_ff == ST_SCAN);
   assign ctl.first  = (count_ff == '0);
   assign ctl.finish = (state_ff == ST_CALC);

   tppd_track u_track (
      .clock     (clock),
      .ctl       (ctl),
      .sample_in (chain[N-1]),
      .span      (span)
   );

   // decision on registered spans and registered cooldown check
   assign over = (span.x > thr_ff) || (span.y > thr_ff) || (span.z > thr_ff);
   assign tap  = warm_ff && over && !cool_ff;
   assign span_out = warm_ff ? span : '0;

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      warm_in  = warm_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
               count_in = '0;
               if (fill_ff < tppd_pkg::FILL_W'(N)) begin
                  fill_in = fill_ff + 1'b1;
               end
               warm_in = (fill_in == tppd_pkg::FILL_W'(N));
            end
         end
         ST_SCAN: begin
            if (count_ff == tppd_pkg::CNT_W'(N - 1)) begin
               state_in = ST_CALC;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fill_ff      <= '0;
         warm_ff      <= 1'b0;
         last_ff      <= '0;
         had_ff       <= 1'b0;
         thr_ff       <= tppd_pkg::THRESHOLD_RESET;
         cooldown_ff  <= tppd_pkg::COOLDOWN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         warm_ff  <= warm_in;
         if (csr_valid) begin
            if (csr_index == tppd_pkg::CSR_THRESHOLD) thr_ff <= csr_data[15:0];
            if (csr_index == tppd_pkg::CSR_COOLDOWN)  cooldown_ff <= csr_data;
         end
         if (load_rsp && tap) begin
            last_ff <= stamp_ff;
            had_ff  <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stamp_ff <= req_tdata[79:48];
      end
      if (state_ff == ST_CALC) begin
         cool_ff <= had_ff && ((stamp_ff - last_ff) < cooldown_ff);
      end
      if (load_rsp) begin
         rsp_data_ff <= {6'd0, span_out.z, span_out.y, span_out.x, warm_ff, tap};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          RANDOM_SETS  = 8;
   localparam int          SET_ITEMS    = 66;
   // indexes outside the register map, writes there must change nothing
   localparam logic [1:0]  CSR_UNMAPPED_A = 2'd2;
   localparam logic [1:0]  CSR_UNMAPPED_B = 2'd3;

   typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_type;

   typedef struct packed {
      logic        tap;
      logic        warmed;
      logic [15:0] span_x;
      logic [15:0] span_y;
      logic [15:0] span_z;
   } verdict_type;

   typedef struct {
      row_kind_type         kind;
      logic [1:0]           reg_idx;
      logic [31:0]          reg_data;
      tppd_pkg::sample_type s;
      logic [31:0]          stamp;
      bit                   typed;
      verdict_type          want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   tap_peak_to_peak_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // tap predictor state
   tppd_pkg::sample_type win [tppd_pkg::WINDOW_LEN];
   int unsigned slot_ptr       = 0;
   int unsigned fill           = 0;
   logic [31:0] last_tap_stamp = '0;
   bit          had_tap        = 1'b0;
   logic [15:0] threshold      = tppd_pkg::THRESHOLD_RESET;
   logic [31:0] cooldown       = tppd_pkg::COOLDOWN_RESET;

   verdict_type  expected_verdicts[$];
   stim_row_type stim_rows[$];
   verdict_type  rsp_want;
   int           n_fail         = 0;
   int           cycle_count    = 0;
   int           send_idle_pct  = 0;
   int           stall_pct      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic verdict_type detect_tap(tppd_pkg::sample_type s,
                                              logic [31:0] stamp);
      verdict_type v;
      int          lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
      logic [31:0] since_tap;
      win[slot_ptr] = s;
      slot_ptr = (slot_ptr == tppd_pkg::WINDOW_LEN - 1) ? 0 : slot_ptr + 1;
      if (fill < tppd_pkg::WINDOW_LEN) fill++;
      v = '0;
      if (fill == tppd_pkg::WINDOW_LEN) begin
         lo_x = int'(win[0].x); hi_x = lo_x;
         lo_y = int'(win[0].y); hi_y = lo_y;
         lo_z = int'(win[0].z); hi_z = lo_z;
         for (int i = 1; i < tppd_pkg::WINDOW_LEN; i++) begin
            if (int'(win[i].x) < lo_x) lo_x = int'(win[i].x);
            if (int'(win[i].x) > hi_x) hi_x = int'(win[i].x);
            if (int'(win[i].y) < lo_y) lo_y = int'(win[i].y);
            if (int'(win[i].y) > hi_y) hi_y = int'(win[i].y);
            if (int'(win[i].z) < lo_z) lo_z = int'(win[i].z);
            if (int'(win[i].z) > hi_z) hi_z = int'(win[i].z);
         end
         v.warmed = 1'b1;
         v.span_x = 16'(hi_x - lo_x);
         v.span_y = 16'(hi_y - lo_y);
         v.span_z = 16'(hi_z - lo_z);
         v.tap = (v.span_x > threshold) || (v.span_y > threshold) ||
                 (v.span_z > threshold);
         since_tap = stamp - last_tap_stamp;
         if (v.tap && had_tap && since_tap < cooldown) v.tap = 1'b0;
         if (v.tap) begin
            last_tap_stamp = stamp;
            had_tap = 1'b1;
         end
      end
      return v;
   endfunction

   function automatic void add_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                      logic signed [15:0] az, logic [31:0] stamp,
                                      bit typed, verdict_type want);
      stim_row_type r;
      r.kind  = ROW_SAMPLE;
      r.reg_idx = '0;
      r.reg_data = '0;
      r.s     = '{x: ax, y: ay, z: az};
      r.stamp = stamp;
      r.typed = typed;
      r.want  = want;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_write(logic [1:0] idx, logic [31:0] data);
      stim_row_type r;
      r = '{kind: ROW_WRITE, reg_idx: idx, reg_data: data, s: '0, stamp: '0,
            typed: 1'b0, want: '0};
      stim_rows.push_back(r);
   endfunction

   // baseline plus bounded jitter, with an occasional full-range spike
   function automatic logic [15:0] axis_value(int base, int amp, int spike_pct);
      int v;
      if ($urandom_range(0, 99) < spike_pct) return 16'($urandom());
      v = base + int'($urandom_range(0, amp)) - amp / 2;
      return v[15:0];
   endfunction

   task automatic send_sample(tppd_pkg::sample_type s, logic [31:0] stamp, bit typed,
                              verdict_type want);
      verdict_type v;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, s};
      do @(posedge clock); while (!req_tready);
      v = detect_tap(s, stamp);
      expected_verdicts.push_back(typed ? want : v);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tppd_pkg::CSR_THRESHOLD: threshold = data[15:0];
         tppd_pkg::CSR_COOLDOWN:  cooldown  = data;
         default: ;
      endcase
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_fail++;
      end
   endtask

   // response side: check on every accepted beat, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $error("rsp beat %h with no sample pending", rsp_tdata);
            n_fail++;
         end else begin
            rsp_want = expected_verdicts.pop_front();
            check_field("tap",    rsp_want.tap,    rsp_tdata[0]);
            check_field("warmed", rsp_want.warmed, rsp_tdata[1]);
            check_field("span_x", rsp_want.span_x, rsp_tdata[17:2]);
            check_field("span_y", rsp_want.span_y, rsp_tdata[33:18]);
            check_field("span_z", rsp_want.span_z, rsp_tdata[49:34]);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      tppd_pkg::sample_type s;
      logic [31:0] stamp;
      bit          writing;
      int          amp, base, spike_pct, thr_top, r;
      int unsigned step_cap;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = tppd_pkg::CSR_THRESHOLD;
      csr_data   = '0;

      // directed: fill the window with one extreme sample at the front
      add_sample(-16'sd32768, 16'sd32767, 16'sd0, 32'd0, 1'b1, '0);
      for (int i = 1; i < tppd_pkg::WINDOW_LEN - 1; i++)
         add_sample(16'sd0, 16'sd0, 16'sd0, 32'(1000 * i), 1'b1, '0);
      // first warm beat, first tap ever: no cooldown yet
      add_sample(16'sd0, 16'sd0, 16'sd0, 32'd20000, 1'b1,
                 '{1'b1, 1'b1, 16'd32768, 16'd32767, 16'd0});
      // one tick after the tap: suppressed
      add_sample(16'sd0, 16'sd0, -16'sd32768, 32'd20001, 1'b1,
                 '{1'b0, 1'b1, 16'd0, 16'd0, 16'd32768});
      // exactly cooldown after the tap: reported, full-scale z span
      add_sample(16'sd32767, 16'sd0, 16'sd32767, 32'd170000, 1'b1,
                 '{1'b1, 1'b1, 16'd32767, 16'd0, 16'd65535});
      // span equal to threshold is no tap
      add_write(tppd_pkg::CSR_THRESHOLD, 32'h0000_FFFF);
      add_sample(16'sd0, 16'sd0, 16'sd0, 32'd170001, 1'b1,
                 '{1'b0, 1'b1, 16'd32767, 16'd0, 16'd65535});
      // zero cooldown never suppresses; unmapped writes would break this row
      add_write(tppd_pkg::CSR_THRESHOLD, 32'd32767);
      add_write(tppd_pkg::CSR_COOLDOWN, 32'd0);
      add_write(CSR_UNMAPPED_A, 32'h0000_FFFF);
      add_write(CSR_UNMAPPED_B, 32'hFFFF_FFFF);
      add_sample(16'sd0, 16'sd0, 16'sd0, 32'd170002, 1'b1,
                 '{1'b1, 1'b1, 16'd32767, 16'd0, 16'd65535});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_data);
            writing = 1'b1;
         end else begin
            if (writing) csr_valid <= 1'b0;
            writing = 1'b0;
            send_sample(stim_rows[i].s, stim_rows[i].stamp, stim_rows[i].typed,
                        stim_rows[i].want);
         end
      end

      stamp = 32'd170002;
      for (int p = 0; p < RANDOM_SETS; p++) begin
         amp       = $urandom_range(100, 40000);
         base      = int'($urandom_range(0, 16000)) - 8000;
         spike_pct = $urandom_range(0, 15);
         thr_top   = (amp + amp / 2 > 65535) ? 65535 : amp + amp / 2;
         case (p)
            0: begin
               write_reg(tppd_pkg::CSR_THRESHOLD, 32'd0);
               write_reg(tppd_pkg::CSR_COOLDOWN, 32'd0);
            end
            1: begin
               write_reg(tppd_pkg::CSR_THRESHOLD, 32'h0000_FFFF);
               write_reg(tppd_pkg::CSR_COOLDOWN, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(tppd_pkg::CSR_THRESHOLD, 32'(tppd_pkg::THRESHOLD_RESET));
               write_reg(tppd_pkg::CSR_COOLDOWN, tppd_pkg::COOLDOWN_RESET);
               write_reg(CSR_UNMAPPED_A, $urandom());
            end
            default: begin
               write_reg(tppd_pkg::CSR_COOLDOWN, $urandom_range(0, 200000));
               write_reg(tppd_pkg::CSR_THRESHOLD, $urandom_range(0, thr_top));
               if ($urandom_range(0, 1)) write_reg(CSR_UNMAPPED_B, $urandom());
            end
         endcase
         csr_valid <= 1'b0;

         // idle pattern: none, sender gaps, receiver stalls, both light
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase

         // stamp steps of a fraction of the cooldown keep suppression busy
         step_cap = (cooldown == 0) ? 2000 : cooldown / 6 + 1;
         if (step_cap > (1 << 24)) step_cap = 1 << 24;

         for (int i = 0; i < SET_ITEMS; i++) begin
            if (p == 5 && i == SET_ITEMS / 2) begin
               // hold off until the pipe has drained completely
               req_tvalid <= 1'b0;
               while (expected_verdicts.size() != 0) @(posedge clock);
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
               // repeated stamp
            end else if (r < 9) begin
               stamp = $urandom();
            end else if (r < 16 && had_tap) begin
               // around the cooldown edge of the last reported tap
               stamp = last_tap_stamp + cooldown + $urandom_range(0, 2) - 1;
            end else begin
               stamp = stamp + $urandom_range(1, step_cap);
            end
            s.x = axis_value(base, amp, spike_pct);
            s.y = axis_value(base, amp, spike_pct);
            s.z = axis_value(base, amp, spike_pct);
            send_sample(s, stamp, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (n_fail == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tppd_pkg.sv
rtl/tppd_cell.sv
rtl/tppd_track.sv
rtl/tap_peak_to_peak_detector_core.sv
verif/tb.sv
